// ===== src/bmp24_to_rgba_converter_macros.svh =====
// Assertion macros for the BMP 24-bit to RGBA converter.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef BMP24_TO_RGBA_CONVERTER_MACROS_SVH
`define BMP24_TO_RGBA_CONVERTER_MACROS_SVH

// same-cycle implication
`define B2R_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define B2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b2r_pkg.sv =====
// Shared types and constants for the BMP 24-bit to RGBA converter.
// No dependencies.
package b2r_pkg;

  localparam int unsigned DimBitsDefault = 14;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [1:0] StPixel  = 2'd0;
  localparam logic [1:0] StFormat = 2'd1;
  localparam logic [1:0] StSize   = 2'd2;

  localparam logic [1:0] AlphaNone = 2'd0;
  localparam logic [1:0] AlphaKey  = 2'd1;
  localparam logic [1:0] AlphaAvg  = 2'd2;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [1:0] status;
    logic       last_pixel;
  } out_t;

  // front-to-back transaction
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] status;
    logic       last_pixel;
    logic       key_pixel;
  } item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ===== src/b2r_front.sv =====
// Front end: header capture, format/size check, pixel gathering, row padding.
// Depends on b2r_pkg; pushes transactions into b2r_fifo.
module b2r_front #(
  parameter int unsigned DimBits = b2r_pkg::DimBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  b2r_pkg::in_t     in_data_i,
  input  b2r_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output b2r_pkg::item_t   push_item_o
);
  import b2r_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHead = 2'd1;
  localparam logic [1:0] PhPix  = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  localparam logic [5:0] OffWidth  = 6'd18;
  localparam logic [5:0] OffHeight = 6'd22;
  localparam logic [5:0] OffDepth  = 6'd28;
  localparam logic [5:0] OffComp   = 6'd30;
  localparam logic [5:0] OffCheck  = 6'd33;
  localparam logic [5:0] OffLast   = 6'd53;

  localparam logic [31:0] MaxDim = 32'((64'd1 << DimBits) - 64'd1);

  logic [1:0]         phase_q, phase_d;
  logic [5:0]         off_q, off_d;
  logic [31:0]        width_q, width_d;
  logic [31:0]        height_q, height_d;
  logic [15:0]        depth_q, depth_d;
  logic               comp_nz_q, comp_nz_d;
  logic [DimBits-1:0] col_q, col_d;
  logic [DimBits-1:0] row_q, row_d;
  logic [1:0]         pad_q, pad_d;
  logic [1:0]         bip_q, bip_d;
  logic [15:0]        held_q, held_d;
  logic               key_taken_q, key_taken_d;

  logic accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  always_comb begin
    logic [7:0]         byte_v;
    logic [4:0]         sel32;
    logic [3:0]         sel16;
    logic               fmt_err;
    logic               size_err;
    logic [DimBits-1:0] wid;
    logic [DimBits-1:0] hgt;
    logic               col_end;
    logic               row_end;

    byte_v      = in_data_i.file_byte;
    phase_d     = phase_q;
    off_d       = off_q;
    width_d     = width_q;
    height_d    = height_q;
    depth_d     = depth_q;
    comp_nz_d   = comp_nz_q;
    col_d       = col_q;
    row_d       = row_q;
    pad_d       = pad_q;
    bip_d       = bip_q;
    held_d      = held_q;
    key_taken_d = key_taken_q;
    push_o      = 1'b0;
    push_item_o = '0;
    sel32       = '0;
    sel16       = '0;
    fmt_err     = 1'b0;
    size_err    = 1'b0;
    wid         = '0;
    hgt         = '0;
    col_end     = 1'b0;
    row_end     = 1'b0;

    if (accept) begin
      if (in_data_i.first_byte) begin
        phase_d     = PhHead;
        off_d       = '0;
        width_d     = '0;
        height_d    = '0;
        depth_d     = '0;
        comp_nz_d   = 1'b0;
        key_taken_d = 1'b0;
      end

      unique case (phase_d)
        PhHead: begin
          if (off_d >= OffWidth && off_d < OffHeight) begin
            sel32 = {2'(off_d - OffWidth), 3'b000};
            width_d[sel32 +: 8] = byte_v;
          end else if (off_d >= OffHeight && off_d < OffHeight + 6'd4) begin
            sel32 = {2'(off_d - OffHeight), 3'b000};
            height_d[sel32 +: 8] = byte_v;
          end else if (off_d >= OffDepth && off_d < OffComp) begin
            sel16 = {1'(off_d - OffDepth), 3'b000};
            depth_d[sel16 +: 8] = byte_v;
          end else if (off_d >= OffComp && off_d <= OffCheck) begin
            comp_nz_d = comp_nz_d | (byte_v != 8'd0);
          end

          if (off_d == OffCheck) begin
            fmt_err  = (depth_d != 16'd24) || comp_nz_d;
            size_err = (width_d == 32'd0) || (width_d > MaxDim) ||
                       (height_d == 32'd0) || (height_d > MaxDim);
          end

          if (fmt_err || size_err) begin
            push_o                 = 1'b1;
            push_item_o.status     = fmt_err ? StFormat : StSize;
            push_item_o.last_pixel = 1'b1;
            phase_d                = PhDone;
          end else if (off_d >= OffLast) begin
            phase_d = PhPix;
            col_d   = '0;
            row_d   = '0;
            pad_d   = '0;
            bip_d   = '0;
          end else begin
            off_d = off_d + 6'd1;
          end
        end
        PhPix: begin
          wid     = width_d[DimBits-1:0];
          hgt     = height_d[DimBits-1:0];
          col_end = (col_d == wid - DimBits'(1));
          row_end = (row_d == hgt - DimBits'(1));
          if (col_d >= wid) begin
            pad_d = pad_d + 2'd1;
            if (pad_d == width_d[1:0]) begin
              pad_d = '0;
              col_d = '0;
              row_d = row_d + DimBits'(1);
            end
          end else if (bip_d == 2'd0) begin
            held_d[7:0] = byte_v;
            bip_d       = 2'd1;
          end else if (bip_d == 2'd1) begin
            held_d[15:8] = byte_v;
            bip_d        = 2'd2;
          end else begin
            bip_d                  = 2'd0;
            push_o                 = 1'b1;
            push_item_o.red        = byte_v;
            push_item_o.green      = held_d[15:8];
            push_item_o.blue       = held_d[7:0];
            push_item_o.status     = StPixel;
            push_item_o.last_pixel = col_end && row_end;
            push_item_o.key_pixel  = ~key_taken_d;
            key_taken_d            = 1'b1;
            if (col_end && row_end) begin
              phase_d = PhDone;
            end else if (col_end && width_d[1:0] == 2'd0) begin
              col_d = '0;
              row_d = row_d + DimBits'(1);
            end else begin
              col_d = col_d + DimBits'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      off_q       <= '0;
      width_q     <= '0;
      height_q    <= '0;
      depth_q     <= '0;
      comp_nz_q   <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      pad_q       <= '0;
      bip_q       <= '0;
      key_taken_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      off_q       <= off_d;
      width_q     <= width_d;
      height_q    <= height_d;
      depth_q     <= depth_d;
      comp_nz_q   <= comp_nz_d;
      col_q       <= col_d;
      row_q       <= row_d;
      pad_q       <= pad_d;
      bip_q       <= bip_d;
      key_taken_q <= key_taken_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

endmodule

// ===== src/b2r_fifo.sv =====
// Short register queue between front and back ends.
// Depends on b2r_pkg for the transaction and status types.
module b2r_fifo #(
  parameter int unsigned Depth = b2r_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b2r_pkg::item_t   push_item_i,
  input  logic             pop_i,
  output b2r_pkg::item_t   pop_item_o,
  output b2r_pkg::q_stat_t q_stat_o
);
  import b2r_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.valid = (cnt_q != '0);
  assign pop_item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/b2r_back.sv =====
// Back end: alpha generation (color key or RGB average) and output register.
// Depends on b2r_pkg; pops transactions from b2r_fifo.
module b2r_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  b2r_pkg::q_stat_t q_stat_i,
  input  b2r_pkg::item_t   pop_item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output b2r_pkg::out_t    out_data_o
);
  import b2r_pkg::*;

  // floor(s / 3) = (s * 683) >> 11 for s <= 765
  localparam logic [19:0] RecipThird = 20'd683;
  localparam int unsigned RecipShift = 11;

  logic [1:0]  mode_q;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic [23:0] key_q, key_d;
  logic        take;

  assign take        = q_stat_i.valid & (~out_valid_q | ~out_stall_i);
  assign pop_o       = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    logic [23:0] colour;
    logic [9:0]  sum;
    logic [19:0] prod;

    colour = {pop_item_i.red, pop_item_i.green, pop_item_i.blue};
    sum    = 10'(pop_item_i.red) + 10'(pop_item_i.green) + 10'(pop_item_i.blue);
    prod   = 20'(sum) * RecipThird;
    key_d  = pop_item_i.key_pixel ? colour : key_q;

    out_d.red        = pop_item_i.red;
    out_d.green      = pop_item_i.green;
    out_d.blue       = pop_item_i.blue;
    out_d.alpha      = 8'd0;
    out_d.status     = pop_item_i.status;
    out_d.last_pixel = pop_item_i.last_pixel;

    if (pop_item_i.status == StPixel) begin
      unique case (mode_q)
        AlphaKey: begin
          if (colour == key_d) begin
            out_d.red   = 8'd0;
            out_d.green = 8'd0;
            out_d.blue  = 8'd0;
          end else begin
            out_d.alpha = 8'd255;
          end
        end
        AlphaAvg: out_d.alpha = prod[RecipShift +: 8];
        default:  out_d.alpha = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= AlphaNone;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
      key_q <= key_d;
    end
  end

endmodule

// ===== src/bmp24_to_rgba_converter.sv =====
// Top level of the streaming BMP 24-bit to RGBA converter.
// Depends on b2r_pkg, b2r_front, b2r_fifo, b2r_back and the assertion macros.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i   (file byte)
//  out     | output    | out_valid_o/out_stall_i | out_data_o  (RGBA/status)
//  cfg     | input     | cfg_we_i                | cfg_wdata_i (alpha mode)
//
// One file byte per cycle is accepted while in_stall_o is low; a result is
// queued by the front decode, then registered in the alpha stage output.
// in_stall_o rises only while the two-entry queue is full, i.e. when the
// output has been stalled long enough to back results up.
// Reset clears the parser to idle, empties the queue and the output register
// and sets the alpha mode to none.
module bmp24_to_rgba_converter #(
  parameter int unsigned DimBits = b2r_pkg::DimBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  b2r_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output b2r_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i
);
  import b2r_pkg::*;

  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   pop_item;
  q_stat_t q_stat;
  logic    err_zero;

  assign err_zero = out_data_o.last_pixel && out_data_o.alpha == 8'd0 &&
                    out_data_o.red == 8'd0 && out_data_o.green == 8'd0 &&
                    out_data_o.blue == 8'd0;

  b2r_front #(
    .DimBits(DimBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_item_o(push_item)
  );

  b2r_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .pop_item_o (pop_item),
    .q_stat_o   (q_stat)
  );

  b2r_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_stat_i   (q_stat),
    .pop_item_i (pop_item),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`include "bmp24_to_rgba_converter_macros.svh"

  `B2R_ASSERT_IMPL(a_no_overflow, push, !q_stat.full, "push into full queue")
  `B2R_ASSERT_IMPL(a_pop_nonempty, pop, q_stat.valid, "pop from empty queue")
  `B2R_ASSERT_NEXT(a_push_lands, push && !pop, q_stat.valid, "pushed transaction lost")
  `B2R_ASSERT_IMPL(a_err_result, out_valid_o && out_data_o.status != StPixel, err_zero, "error result not cleared")

endmodule

// ===== tb/sv/bmp24_to_rgba_converter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bmp24_to_rgba_converter: streams BMP files and
// checks every pixel or error result against a built-in parser model.
// Depends on b2r_pkg and the converter RTL.
module bmp24_to_rgba_converter_tb;
  import b2r_pkg::*;

  localparam logic [31:0] MaxDim       = (32'd1 << DimBitsDefault) - 1;
  localparam logic [15:0] BmpDepth     = 16'd24;
  localparam logic [1:0]  AlphaSpare   = 2'd3;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned DrainLimit   = 5000;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned RandomBytes  = 40;

  typedef enum logic [1:0] {PhIdle, PhHeader, PhPixels, PhDone} parse_phase_e;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid;
  logic  in_stall;
  in_t   in_data;
  logic  out_valid;
  logic  out_stall;
  out_t  out_data;
  logic  cfg_we;
  logic  [1:0] cfg_wdata;

  bit          quiet = 1'b0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_fed = 0;
  int unsigned cycle_cnt = 0;
  int unsigned stall_run = 0;
  logic [7:0]  body_q[$];

  // parser model state
  parse_phase_e phase_m;
  int unsigned  hdr_pos;
  logic [31:0]  width_m, height_m, comp_m;
  logic [15:0]  depth_m;
  int unsigned  col_m, row_m;
  logic [1:0]   pad_m, bip_m;
  logic [15:0]  held_m;
  logic [23:0]  key_m;
  logic         key_ok_m;
  logic [1:0]   mode_m = AlphaNone;
  out_t         pixel_q[$];

  bmp24_to_rgba_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_run > 0) begin
        out_stall = 1'b1;
        stall_run--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_run = draw_gap();
      end
    end
  end

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic clear_parser();
    phase_m  = PhIdle;
    hdr_pos  = 0;
    width_m  = '0;
    height_m = '0;
    comp_m   = '0;
    depth_m  = '0;
    col_m    = 0;
    row_m    = 0;
    pad_m    = '0;
    bip_m    = '0;
    held_m   = '0;
    key_m    = '0;
    key_ok_m = 1'b0;
  endtask

  task automatic parse_byte(input in_t it);
    out_t        res;
    logic [23:0] rgb;
    logic [1:0]  pad;
    logic [1:0]  status;
    bit          is_last;
    res = '0;
    if (it.first_byte) begin
      clear_parser();
      phase_m = PhHeader;
    end
    case (phase_m)
      PhHeader: begin
        if (hdr_pos >= 18 && hdr_pos <= 21)
          width_m |= 32'(it.file_byte) << (8 * (hdr_pos - 18));
        else if (hdr_pos >= 22 && hdr_pos <= 25)
          height_m |= 32'(it.file_byte) << (8 * (hdr_pos - 22));
        else if (hdr_pos >= 28 && hdr_pos <= 29)
          depth_m |= 16'(it.file_byte) << (8 * (hdr_pos - 28));
        else if (hdr_pos >= 30 && hdr_pos <= 33)
          comp_m |= 32'(it.file_byte) << (8 * (hdr_pos - 30));
        if (hdr_pos == 33) begin
          status = StPixel;
          if (depth_m != BmpDepth || comp_m != 0)
            status = StFormat;
          else if (width_m == 0 || width_m > MaxDim || height_m == 0 || height_m > MaxDim)
            status = StSize;
          if (status != StPixel) begin
            phase_m = PhDone;
            res.status = status;
            res.last_pixel = 1'b1;
            pixel_q.push_back(res);
            return;
          end
        end
        if (hdr_pos >= 53) begin
          phase_m = PhPixels;
          col_m = 0;
          row_m = 0;
          pad_m = '0;
          bip_m = '0;
        end else begin
          hdr_pos++;
        end
      end
      PhPixels: begin
        pad = width_m[1:0];
        if (col_m >= width_m) begin
          pad_m++;
          if (pad_m == pad) begin
            pad_m = '0;
            col_m = 0;
            row_m++;
          end
          return;
        end
        if (bip_m == 0) begin
          held_m = {8'h00, it.file_byte};
          bip_m = 2'd1;
          return;
        end
        if (bip_m == 1) begin
          held_m[15:8] = it.file_byte;
          bip_m = 2'd2;
          return;
        end
        bip_m = '0;
        rgb = {it.file_byte, held_m[15:8], held_m[7:0]};
        if (!key_ok_m) begin
          key_m = rgb;
          key_ok_m = 1'b1;
        end
        res.red   = rgb[23:16];
        res.green = rgb[15:8];
        res.blue  = rgb[7:0];
        case (mode_m)
          AlphaKey: begin
            if (rgb == key_m) begin
              res.red   = '0;
              res.green = '0;
              res.blue  = '0;
            end else begin
              res.alpha = 8'd255;
            end
          end
          AlphaAvg: res.alpha = 8'((32'(res.red) + res.green + res.blue) / 3);
          default: res.alpha = '0;
        endcase
        is_last = (col_m + 1 == width_m) && (row_m + 1 == height_m);
        col_m++;
        if (is_last) begin
          phase_m = PhDone;
        end else if (col_m == width_m && pad == 0) begin
          col_m = 0;
          row_m++;
        end
        res.status = StPixel;
        res.last_pixel = is_last;
        pixel_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data.file_byte = b;
    in_data.first_byte = first;
    do @(posedge clk_i); while (in_stall);
    parse_byte(in_data);
    bytes_fed++;
    @(negedge clk_i);
  endtask

  task automatic send_body(input int n);
    int unsigned sent;
    sent = 0;
    while (body_q.size() > 0 && (n < 0 || sent < n)) begin
      send_byte(body_q.pop_front(), 1'b0);
      sent++;
    end
  endtask

  task automatic send_image(input logic [31:0] w, input logic [31:0] h,
                            input logic [15:0] depth, input logic [31:0] comp,
                            input int cut, input int unsigned tail);
    logic [7:0]  hdr [54];
    logic [23:0] colour, key_colour;
    int unsigned r, c, i;
    bit          ok;
    for (i = 0; i < 54; i++) hdr[i] = 8'($urandom);
    for (i = 0; i < 4; i++) begin
      hdr[18 + i] = w[8*i +: 8];
      hdr[22 + i] = h[8*i +: 8];
      hdr[30 + i] = comp[8*i +: 8];
    end
    hdr[28] = depth[7:0];
    hdr[29] = depth[15:8];
    ok = depth == BmpDepth && comp == 0 && w != 0 && w <= MaxDim && h != 0 && h <= MaxDim;
    key_colour = 24'($urandom);
    body_q.delete();
    if (ok) begin
      for (r = 0; r < h && (cut < 0 || body_q.size() < cut); r++) begin
        for (c = 0; c < w; c++) begin
          case ($urandom_range(0, 9))
            0, 1, 2: colour = key_colour;
            3: colour = '0;
            4: colour = '1;
            default: colour = 24'($urandom);
          endcase
          if (r == 0 && c == 0) key_colour = colour;
          body_q.push_back(colour[7:0]);
          body_q.push_back(colour[15:8]);
          body_q.push_back(colour[23:16]);
        end
        if (r + 1 < h) repeat (w[1:0]) body_q.push_back(8'($urandom));
      end
    end
    // a rejected header ends at the check offset
    for (i = 0; i < (ok ? 54 : 34); i++) send_byte(hdr[i], i == 0);
    send_body(cut);
    repeat (tail) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_alpha_mode(input logic [1:0] m);
    wait_drained();
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(posedge clk_i);
    mode_m = m;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic field_check(input string name, input int got, input int want);
    if (got != want)
      log_mismatch($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
  endtask

  task automatic check_pixel(input out_t got);
    out_t want;
    if (pixel_q.size() == 0) begin
      log_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
    end else begin
      want = pixel_q.pop_front();
      field_check("red", got.red, want.red);
      field_check("green", got.green, want.green);
      field_check("blue", got.blue, want.blue);
      field_check("alpha", got.alpha, want.alpha);
      field_check("status", got.status, want.status);
      field_check("last_pixel", got.last_pixel, want.last_pixel);
    end
    results_seen++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) check_pixel(out_data);
  end

  task automatic test_stray_bytes();
    repeat (6) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_header_errors();
    send_image(32'd4, 32'd2, 16'd32, 32'd0, -1, 2);
    send_image(MaxDim + 1, 32'd1, BmpDepth, 32'd0, -1, 0);
    send_image(32'd3, 32'hFFFF_FFFB, BmpDepth, 32'd0, -1, 2);
    send_image(32'd0, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, -1, 0);
  endtask

  task automatic test_alpha_modes();
    logic [1:0] modes [4];
    modes = '{AlphaNone, AlphaKey, AlphaAvg, AlphaSpare};
    foreach (modes[i]) begin
      set_alpha_mode(modes[i]);
      send_image(32'd1, 32'd1, BmpDepth, 32'd0, -1, 0);
    end
  endtask

  task automatic test_restarts();
    set_alpha_mode(AlphaKey);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom), i == 0);
    send_image(32'd3, 32'd3, BmpDepth, 32'd0, 10, 0);
    send_image(32'd6, 32'd3, BmpDepth, 32'd0, 14, 0);
    set_alpha_mode(AlphaAvg);
    send_body(20);
    set_alpha_mode(AlphaKey);
    send_body(-1);
    send_byte(8'($urandom), 1'b0);
  endtask

  task automatic test_max_sizes();
    quiet = 1'b1;
    set_alpha_mode(AlphaAvg);
    send_image(MaxDim, 32'd1, BmpDepth, 32'd0, 3, 0);
    send_image(32'd1, MaxDim, BmpDepth, 32'd0, 3, 0);
    quiet = 1'b0;
  endtask

  task automatic test_random_streams();
    int unsigned stop_at, kind;
    logic [31:0] w, h;
    stop_at = bytes_fed + RandomBytes;
    while (bytes_fed < stop_at) begin
      if ($urandom_range(0, 5) == 0) set_alpha_mode(2'($urandom));
      quiet = ($urandom_range(0, 7) == 0);
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      h = $urandom_range(1, 4);
      kind = $urandom_range(0, 19);
      case (kind)
        0: send_image(w, h, 16'($urandom), 32'd0, -1, $urandom_range(0, 3));
        1: send_image(w, h, BmpDepth,
                      32'($urandom_range(1, 255)) << (8 * $urandom_range(0, 3)), -1, 2);
        2: begin
          if ($urandom_range(0, 1) == 0)
            w = $urandom_range(0, 1) ? 32'd0 : 32'($urandom) | (MaxDim + 1);
          else
            h = $urandom_range(0, 1) ? 32'd0 : 32'($urandom) | (MaxDim + 1);
          send_image(w, h, BmpDepth, 32'd0, -1, $urandom_range(0, 3));
        end
        3, 4: send_image(w, h, BmpDepth, 32'd0, $urandom_range(0, 20), 0);
        5: repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        6: for (int i = 0; i < $urandom_range(1, 53); i++) send_byte(8'($urandom), i == 0);
        default: send_image(w, h, BmpDepth, 32'd0, -1, $urandom_range(0, 3));
      endcase
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned waited;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = AlphaNone;
    rst_ni    = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_stray_bytes();
    test_header_errors();
    test_alpha_modes();
    test_restarts();
    test_max_sizes();
    test_random_streams();

    in_valid = 1'b0;
    waited = 0;
    while (pixel_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(negedge clk_i);
    if (pixel_q.size() != 0)
      log_mismatch($sformatf("%0d expected results never arrived", pixel_q.size()));
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/b2r_pkg.sv
src/b2r_front.sv
src/b2r_fifo.sv
src/b2r_back.sv
src/bmp24_to_rgba_converter.sv
tb/sv/bmp24_to_rgba_converter_tb.sv
